// ===== design/pba_pkg.sv =====
// shared types and constants for the page bitmap allocator
package pba_pkg;

   localparam int PAGE_BYTES_DEF = 4096;
   localparam int MAX_PAGES_DEF  = 4096;
   localparam int ADDR_W         = 32;
   localparam int CFG_W          = 13;
   localparam int MAP_BITS       = 32;
   localparam int BIT_W          = 5;

   localparam logic [CFG_W-1:0] TOTAL_RESET = 13'd4096;

   typedef enum logic [1:0] {
      CMD_ALLOC     = 2'd0,
      CMD_FREE      = 2'd1,
      CMD_MARK_USED = 2'd2,
      CMD_MARK_FREE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SETUP = 2'd1,
      ST_SCAN  = 2'd2,
      ST_DONE  = 2'd3
   } state_type;

   typedef enum logic [1:0] {
      MODE_ALLOC = 2'd0,
      MODE_SET   = 2'd1,
      MODE_CLEAR = 2'd2
   } word_mode_type;

   typedef struct packed {
      word_mode_type    mode;
      logic [BIT_W-1:0] lo;
      logic [BIT_W-1:0] hi;
   } word_op_type;

endpackage

// ===== design/pba_map_mem.sv =====
// bitmap word memory with per-word valid bits cleared at reset
module pba_map_mem
   import pba_pkg::*;
#(
   parameter int MAP_WORDS = MAX_PAGES_DEF / MAP_BITS,
   parameter int IDX_W     = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_idx,
   output logic [MAP_BITS-1:0] rd_data,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_idx,
   input  logic [MAP_BITS-1:0] wr_data
);

   logic [MAP_BITS-1:0] map_ff [MAP_WORDS];
   logic [MAP_WORDS-1:0] vld_ff;
   logic [MAP_BITS-1:0] rd_word_ff;
   logic                rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_ff[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff <= map_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_idx] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_idx];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_word_ff : '0;

endmodule

// ===== design/pba_word_unit.sv =====
// shared word unit: lowest free bit search and range mask update
module pba_word_unit
   import pba_pkg::*;
(
   input  logic [MAP_BITS-1:0] word,
   input  word_op_type         op,
   output logic [MAP_BITS-1:0] new_word,
   output logic                found,
   output logic [BIT_W-1:0]    bit_idx
);

   localparam logic [MAP_BITS-1:0] ONES = '1;

   logic [MAP_BITS-1:0] inv;
   logic [MAP_BITS-1:0] low;
   logic [MAP_BITS-1:0] mask;

   always_comb begin
      inv   = ~word;
      low   = inv & (~inv + {{(MAP_BITS-1){1'b0}}, 1'b1});
      found = |inv;
      mask  = (ONES << op.lo) & (ONES >> (BIT_W'(MAP_BITS - 1) - op.hi));
      bit_idx = '0;
      for (int b = 0; b < MAP_BITS; b++) begin
         if (low[b]) begin
            bit_idx = bit_idx | BIT_W'(b);
         end
      end
      unique case (op.mode)
         MODE_ALLOC: new_word = word | low;
         MODE_SET:   new_word = word | mask;
         MODE_CLEAR: new_word = word & ~mask;
         default:    new_word = word;
      endcase
   end

endmodule

// ===== design/page_bitmap_allocator.sv =====
// page bitmap allocator top level: sequencer, config register and response stage
// allocate scans bitmap words from the first up to the hit or the last word; range and free
// commands walk the bitmap words spanned; empty ranges go from setup straight to done
// one request at a time, set by the single memory read port walking one word per cycle
// the response register lets the next request in while a response waits
// reset clears per-word valid bits at once, so the whole bitmap reads free immediately
module page_bitmap_allocator
   import pba_pkg::*;
#(
   parameter int PAGE_BYTES = PAGE_BYTES_DEF,
   parameter int MAX_PAGES  = MAX_PAGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_cmd,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [ADDR_W-1:0] req_length,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ADDR_W-1:0] rsp_alloc_address,
   output logic              rsp_status,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CFG_W-1:0]  csr_total_blocks
);

   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int FIRST_W    = ADDR_W - PAGE_SHIFT;
   localparam int MAP_WORDS  = (MAX_PAGES + MAP_BITS - 1) / MAP_BITS;
   localparam int IDX_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int PAGE_W     = $clog2(MAX_PAGES + 1);

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [FIRST_W-1:0]   first_ff, first_in;
   logic [FIRST_W-1:0]   count_ff, count_in;
   logic [CFG_W-1:0]     total_ff;
   logic [IDX_W-1:0]     cursor_ff, cursor_in;
   logic [IDX_W-1:0]     fw_ff, fw_in;
   logic [IDX_W-1:0]     last_ff, last_in;
   logic [BIT_W-1:0]     lo_ff, lo_in;
   logic [BIT_W-1:0]     hi_ff, hi_in;
   logic                 iss_done_ff, iss_done_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [ADDR_W-1:0]    res_addr_ff, res_addr_in;
   logic                 res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic                 rsp_status_ff, rsp_status_in;

   logic                 accept;
   logic [PAGE_W-1:0]    pages_c;
   logic [PAGE_W-1:0]    words_lim;
   logic [FIRST_W:0]     end_sum;
   logic [PAGE_W-1:0]    end_c;
   logic [PAGE_W-1:0]    first_pg;
   logic [PAGE_W-1:0]    last_pg;
   logic                 range_empty;
   logic                 is_alloc;
   logic                 finish;
   logic                 issue;
   logic                 load_rsp;
   logic [63:0]          addr_wide;

   logic [MAP_BITS-1:0]  rd_data;
   logic [MAP_BITS-1:0]  new_word;
   logic                 found;
   logic [BIT_W-1:0]     bit_idx;
   word_op_type          op;
   logic                 wr_en;

   pba_map_mem #(
      .MAP_WORDS (MAP_WORDS),
      .IDX_W     (IDX_W)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (issue),
      .rd_idx  (cursor_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_idx  (rd_idx_ff),
      .wr_data (new_word)
   );

   pba_word_unit u_word (
      .word     (rd_data),
      .op       (op),
      .new_word (new_word),
      .found    (found),
      .bit_idx  (bit_idx)
   );

   // setup arithmetic
   always_comb begin
      pages_c   = (32'(total_ff) > 32'(MAX_PAGES)) ? PAGE_W'(MAX_PAGES) : PAGE_W'(total_ff);
      words_lim = pages_c >> BIT_W;
      end_sum   = {1'b0, first_ff} + {1'b0, count_ff};
      end_c     = (33'(end_sum) > 33'(MAX_PAGES)) ? PAGE_W'(MAX_PAGES) : PAGE_W'(end_sum);
      first_pg  = PAGE_W'(first_ff);
      last_pg   = end_c - PAGE_W'(1);
      range_empty = (33'(first_ff) >= 33'(MAX_PAGES)) || (count_ff == '0)
                    || (33'(end_sum) <= 33'(first_ff));
   end

   // scan datapath
   always_comb begin
      is_alloc = (cmd_ff == CMD_ALLOC);
      if (is_alloc) begin
         op.mode = MODE_ALLOC;
      end else if (cmd_ff == CMD_MARK_USED) begin
         op.mode = MODE_SET;
      end else begin
         op.mode = MODE_CLEAR;
      end
      op.lo = (rd_idx_ff == fw_ff) ? lo_ff : '0;
      op.hi = (rd_idx_ff == last_ff) ? hi_ff : BIT_W'(MAP_BITS - 1);
      addr_wide = 64'({rd_idx_ff, bit_idx}) << PAGE_SHIFT;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (is_alloc ? (words_lim == '0) : range_empty) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (finish) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs and register updates
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      accept    = req_valid && req_ready;
      finish    = (state_ff == ST_SCAN) && rd_vld_ff
                  && ((is_alloc && found) || (rd_idx_ff == last_ff));
      issue     = (state_ff == ST_SCAN) && !iss_done_ff && !finish;
      wr_en     = (state_ff == ST_SCAN) && rd_vld_ff && (!is_alloc || found);
      load_rsp  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

      cmd_in        = cmd_ff;
      first_in      = first_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      fw_in         = fw_ff;
      last_in       = last_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      iss_done_in   = iss_done_ff;
      rd_vld_in     = issue;
      rd_idx_in     = issue ? cursor_ff : rd_idx_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (accept) begin
         cmd_in        = cmd_type'(req_cmd);
         first_in      = FIRST_W'(req_address >> PAGE_SHIFT);
         count_in      = (cmd_type'(req_cmd) == CMD_FREE) ? FIRST_W'(1)
                                                          : FIRST_W'(req_length >> PAGE_SHIFT);
         res_addr_in   = '0;
         res_status_in = 1'b0;
      end

      if (state_ff == ST_SETUP) begin
         iss_done_in = 1'b0;
         if (is_alloc) begin
            cursor_in = '0;
            fw_in     = '0;
            last_in   = IDX_W'(words_lim - PAGE_W'(1));
            lo_in     = '0;
            hi_in     = BIT_W'(MAP_BITS - 1);
            if (words_lim == '0) begin
               res_status_in = 1'b1;
            end
         end else begin
            cursor_in = IDX_W'(first_pg >> BIT_W);
            fw_in     = IDX_W'(first_pg >> BIT_W);
            last_in   = IDX_W'(last_pg >> BIT_W);
            lo_in     = first_pg[BIT_W-1:0];
            hi_in     = last_pg[BIT_W-1:0];
         end
      end

      if (issue) begin
         if (cursor_ff == last_ff) begin
            iss_done_in = 1'b1;
         end else begin
            cursor_in = cursor_ff + IDX_W'(1);
         end
      end

      if ((state_ff == ST_SCAN) && rd_vld_ff && is_alloc) begin
         if (found) begin
            res_addr_in = addr_wide[ADDR_W-1:0];
         end else if (rd_idx_ff == last_ff) begin
            res_status_in = 1'b1;
         end
      end

      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_addr_in   = res_addr_ff;
         rsp_status_in = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= TOTAL_RESET;
         iss_done_ff  <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_done_ff  <= iss_done_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            total_ff <= csr_total_blocks;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      first_ff      <= first_in;
      count_ff      <= count_in;
      cursor_ff     <= cursor_in;
      fw_ff         <= fw_in;
      last_ff       <= last_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      rd_idx_ff     <= rd_idx_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_alloc_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;

`ifndef SYNTH
   a_accept_to_setup: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SETUP))
      else $error("request accepted but sequencer did not enter setup");

   a_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_SCAN) && rd_vld_ff)
      else $error("bitmap write outside a scan");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && rd_vld_ff) |-> (rd_idx_ff <= last_ff) && (rd_idx_ff >= fw_ff))
      else $error("bitmap word read outside the walked range");

   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_alloc_address == '0))
      else $error("failed allocate returned a nonzero address");
`endif

endmodule
